[design/gsst_pkg.sv]
// ----------------------------------------------------------------------------
// gsst_pkg
// Shared widths, constants, register indexes and payload layouts of the
// gripper servo settle tracker.
// ----------------------------------------------------------------------------
package gsst_pkg;

	localparam int ANGLE_W       = 11;
	localparam int SPEED_W       = 10;
	localparam int SETTLE_W      = 20;
	localparam int ELAPSED_W     = 32;
	localparam int CFG_IDX_W     = 3;
	localparam int ANGLE_TOL     = 10;
	localparam int SETTLE_MARGIN = 50;
	// settle = round(delta * 100 / speed), done as (delta*200 + s) / (2*s)
	localparam int SCALE         = 200;
	// dividend max: 2047 * 200 + 1023 < 2**19
	localparam int DVD_W         = 19;
	localparam int DVS_W         = SPEED_W + 1;
	localparam int DIV_CNT_W     = $clog2(DVD_W);

	typedef logic [ANGLE_W-1:0] angle_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLAMP_LOW    = 3'd0,
		REG_CLAMP_HIGH   = 3'd1,
		REG_LEFT_OPEN    = 3'd2,
		REG_RIGHT_OPEN   = 3'd3,
		REG_LEFT_HOPPER  = 3'd4,
		REG_RIGHT_HOPPER = 3'd5,
		REG_LEFT_CLOSE   = 3'd6,
		REG_RIGHT_CLOSE  = 3'd7
	} reg_idx_t;

	localparam angle_t RST_CLAMP_LOW    = 11'd0;
	localparam angle_t RST_CLAMP_HIGH   = 11'd1800;
	localparam angle_t RST_LEFT_OPEN    = 11'd0;
	localparam angle_t RST_RIGHT_OPEN   = 11'd0;
	localparam angle_t RST_LEFT_HOPPER  = 11'd600;
	localparam angle_t RST_RIGHT_HOPPER = 11'd600;
	localparam angle_t RST_LEFT_CLOSE   = 11'd1800;
	localparam angle_t RST_RIGHT_CLOSE  = 11'd1800;

	typedef struct packed {
		angle_t clamp_low;
		angle_t clamp_high;
		angle_t left_open;
		angle_t right_open;
		angle_t left_hopper;
		angle_t right_hopper;
		angle_t left_close;
		angle_t right_close;
	} cfg_regs_t;

	// input tdata, last field in the lowest bits
	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		angle_t             right_request;
		angle_t             left_request;
	} in_data_t;

	// output tdata, last field in the lowest bits
	typedef struct packed {
		logic [1:0]          pad;
		logic                is_closed;
		logic                is_hopper_open;
		logic                is_open;
		logic                busy_res;
		logic [SETTLE_W-1:0] settle_time;
		angle_t              right_drive;
		angle_t              left_drive;
	} out_data_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

[design/gsst_cfg.sv]
// ----------------------------------------------------------------------------
// gsst_cfg
// Configuration register file: clamp limits and the open, hopper and closed
// angle pairs, written through the index/data channel.
// ----------------------------------------------------------------------------
module gsst_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gsst_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  gsst_pkg::angle_t                 cfg_data,
	output gsst_pkg::cfg_regs_t              regs
);
	import gsst_pkg::*;

	cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.clamp_low    <= RST_CLAMP_LOW;
			regs_q.clamp_high   <= RST_CLAMP_HIGH;
			regs_q.left_open    <= RST_LEFT_OPEN;
			regs_q.right_open   <= RST_RIGHT_OPEN;
			regs_q.left_hopper  <= RST_LEFT_HOPPER;
			regs_q.right_hopper <= RST_RIGHT_HOPPER;
			regs_q.left_close   <= RST_LEFT_CLOSE;
			regs_q.right_close  <= RST_RIGHT_CLOSE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CLAMP_LOW:    regs_q.clamp_low    <= cfg_data;
				REG_CLAMP_HIGH:   regs_q.clamp_high   <= cfg_data;
				REG_LEFT_OPEN:    regs_q.left_open    <= cfg_data;
				REG_RIGHT_OPEN:   regs_q.right_open   <= cfg_data;
				REG_LEFT_HOPPER:  regs_q.left_hopper  <= cfg_data;
				REG_RIGHT_HOPPER: regs_q.right_hopper <= cfg_data;
				REG_LEFT_CLOSE:   regs_q.left_close   <= cfg_data;
				REG_RIGHT_CLOSE:  regs_q.right_close  <= cfg_data;
				default:          regs_q              <= regs_q;
			endcase
		end
	end

endmodule

[design/gsst_div.sv]
// ----------------------------------------------------------------------------
// gsst_div
// Bit-serial restoring divider. The dividend shifts out MSB first, one
// quotient bit shifts in per cycle; done pulses with the quotient ready.
// ----------------------------------------------------------------------------
module gsst_div (
	input  logic                clk,
	input  logic                arst_n,
	input  gsst_pkg::div_req_t  req,
	output gsst_pkg::div_rsp_t  rsp
);
	import gsst_pkg::*;

	logic [DVD_W-1:0]     sh_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;

	logic [DVS_W:0]       trial;
	logic                 qbit;
	logic [DVS_W:0]       diff;

	assign trial = {rem_q, sh_q[DVD_W-1]};
	assign qbit  = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays below the divisor, so it fits DVS_W bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			sh_q  <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (run_q) begin
			sh_q  <= {sh_q[DVD_W-2:0], qbit};
			rem_q <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = sh_q;

endmodule

[design/gripper_servo_settle_tracker_core.sv]
// ----------------------------------------------------------------------------
// gripper_servo_settle_tracker_core
// Two-servo gripper tracker: clamps move commands, drives the servos, times
// the settle with a bit-serial divider and reports busy and pose status.
// ----------------------------------------------------------------------------
// Flow after acceptance: PREP, then CHK and CMP (commands only), DIV (commands
//   that drive the servos only), FIN and OUT, which registers the result.
// Throughput: one item at a time; the next is taken the cycle after the
//   result is registered.
// Reset: arst_n clears all tracking state and loads register reset values.
// ----------------------------------------------------------------------------
module gripper_servo_settle_tracker_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// tdata: left_request[10:0], right_request[21:11], speed[31:22]
	input  logic [31:0]                     s_axis_tdata,
	// tuser: op (0 tick, 1 move command)
	input  logic [0:0]                      s_axis_tuser,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// tdata: left_drive[10:0], right_drive[21:11], settle_time[41:22],
	//        busy_res[42], is_open[43], is_hopper_open[44], is_closed[45], zero
	output logic [47:0]                     m_axis_tdata,
	// tuser: drive_valid
	output logic [0:0]                      m_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gsst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  gsst_pkg::angle_t                cfg_data
);
	import gsst_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_PREP = 7'b0000010,
		ST_CHK  = 7'b0000100,
		ST_CMP  = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_FIN  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	function automatic angle_t abs_diff(angle_t a, angle_t b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic logic near(angle_t a, angle_t b);
		return abs_diff(a, b) <= ANGLE_W'(ANGLE_TOL);
	endfunction

	cfg_regs_t regs;
	div_req_t  div_req;
	div_rsp_t  div_rsp;

	state_t               state_q;
	angle_t               left_cur_q, right_cur_q, left_tgt_q, right_tgt_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [SETTLE_W-1:0]  settle_limit_q;
	logic                 started_q, moving_q, drove_q;
	logic                 m_valid_q;

	logic                 op_q;
	in_data_t             in_q;
	angle_t               lt_q, rt_q;
	out_data_t            m_data_q;
	logic                 m_user_q;

	in_data_t             in_data;
	logic                 in_fire, out_free, settle_hit, near_tgt;
	angle_t               lt_c, rt_c, ld, rd, md;
	logic [SPEED_W-1:0]   spd_eff;

	gsst_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	gsst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_data       = in_data_t'(s_axis_tdata);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	// crossed limits: low wins
	assign lt_c = (in_q.left_request < regs.clamp_low) ? regs.clamp_low :
	              (in_q.left_request > regs.clamp_high) ? regs.clamp_high :
	              in_q.left_request;
	assign rt_c = (in_q.right_request < regs.clamp_low) ? regs.clamp_low :
	              (in_q.right_request > regs.clamp_high) ? regs.clamp_high :
	              in_q.right_request;

	assign settle_hit = started_q && moving_q &&
	                    (elapsed_q >= ELAPSED_W'(settle_limit_q));
	assign near_tgt   = near(lt_q, left_tgt_q) && near(rt_q, right_tgt_q);

	assign ld      = abs_diff(lt_q, left_cur_q);
	assign rd      = abs_diff(rt_q, right_cur_q);
	assign md      = (ld >= rd) ? ld : rd;
	assign spd_eff = (in_q.speed <= SPEED_W'(1)) ? SPEED_W'(1) : in_q.speed;

	assign div_req.start    = (state_q == ST_CMP) && !near_tgt;
	assign div_req.dividend = DVD_W'(md) * DVD_W'(SCALE) + DVD_W'(spd_eff);
	assign div_req.divisor  = {spd_eff, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			left_cur_q     <= '0;
			right_cur_q    <= '0;
			left_tgt_q     <= '0;
			right_tgt_q    <= '0;
			elapsed_q      <= '0;
			settle_limit_q <= '0;
			started_q      <= 1'b0;
			moving_q       <= 1'b0;
			drove_q        <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						drove_q <= 1'b0;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (!op_q) begin
						if (elapsed_q != '1) elapsed_q <= elapsed_q + 1'b1;
						state_q <= ST_FIN;
					end else begin
						if (!started_q) begin
							left_cur_q     <= regs.left_close;
							left_tgt_q     <= regs.left_close;
							right_cur_q    <= regs.right_close;
							right_tgt_q    <= regs.right_close;
							elapsed_q      <= '0;
							settle_limit_q <= '0;
							started_q      <= 1'b1;
							moving_q       <= 1'b0;
							drove_q        <= 1'b1;
						end
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (settle_hit) begin
						left_cur_q  <= left_tgt_q;
						right_cur_q <= right_tgt_q;
						moving_q    <= 1'b0;
					end
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= near_tgt ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						settle_limit_q <= SETTLE_W'(div_rsp.quotient) +
						                  SETTLE_W'(SETTLE_MARGIN);
						left_tgt_q     <= lt_q;
						right_tgt_q    <= rt_q;
						elapsed_q      <= '0;
						moving_q       <= 1'b1;
						drove_q        <= 1'b1;
						state_q        <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (settle_hit) begin
						left_cur_q  <= left_tgt_q;
						right_cur_q <= right_tgt_q;
						moving_q    <= 1'b0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q <= s_axis_tuser[0];
			in_q <= in_data;
		end
		if (state_q == ST_PREP) begin
			lt_q <= lt_c;
			rt_q <= rt_c;
		end
		if ((state_q == ST_OUT) && out_free) begin
			m_user_q                <= drove_q;
			m_data_q.pad            <= '0;
			m_data_q.left_drive     <= left_tgt_q;
			m_data_q.right_drive    <= right_tgt_q;
			m_data_q.settle_time    <= settle_limit_q;
			m_data_q.busy_res       <= moving_q;
			m_data_q.is_open        <= !moving_q &&
			                           near(left_cur_q, regs.left_open) &&
			                           near(right_cur_q, regs.right_open);
			m_data_q.is_hopper_open <= !moving_q &&
			                           near(left_cur_q, regs.left_hopper) &&
			                           near(right_cur_q, regs.right_hopper);
			m_data_q.is_closed      <= !moving_q &&
			                           near(left_cur_q, regs.left_close) &&
			                           near(right_cur_q, regs.right_close);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	a_moving_started: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> started_q)
		else $error("moving without first command");

	a_limit_margin: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> settle_limit_q >= SETTLE_W'(SETTLE_MARGIN))
		else $error("settle limit below margin during move");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");

	a_busy_no_pose: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_data_q.busy_res) |->
		!(m_data_q.is_open || m_data_q.is_hopper_open || m_data_q.is_closed))
		else $error("pose status reported while busy");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gripper servo settle tracker. A queue of ticks
// and move commands feeds a stream driver. An in-bench tracker model predicts
// every status word. A monitor checks each output transaction field by field.
// Traffic runs through several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench;
	import gsst_pkg::*;

	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 2000;
	localparam int ROUND_SCALE  = 200;
	localparam int ANGLE_MAX    = 1800;
	localparam int SPEED_MAX    = 1000;

	typedef enum logic {OP_TICK = 1'b0, OP_MOVE = 1'b1} op_t;

	typedef struct packed {
		op_t                op;
		angle_t             lreq;
		angle_t             rreq;
		logic [SPEED_W-1:0] speed;
	} servo_item_t;

	typedef struct packed {
		logic      drive_valid;
		out_data_t data;
	} servo_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [31:0] s_axis_tdata = '0;
	logic [0:0] s_axis_tuser = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [47:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	angle_t cfg_data = '0;

	gripper_servo_settle_tracker_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	servo_item_t   item_backlog[$];
	servo_status_t status_due[$];

	int sender_idle_pct = 0;
	int stall_pct = 0;
	int hold_orders = 0;
	int hold_orders_taken = 0;
	int hold_left = 0;
	bit cmd_taken = 1'b0;
	int quiet_cycles = 0;

	int mismatch_count = 0;
	int results_seen = 0;
	int items_queued = 0;
	int ticks_taken = 0;
	int moves_taken = 0;
	int moves_driven = 0;
	int settles_done = 0;
	int settings_used = 1;

	// tracker model state
	cfg_regs_t tracker_cfg = '{
		clamp_low: RST_CLAMP_LOW, clamp_high: RST_CLAMP_HIGH,
		left_open: RST_LEFT_OPEN, right_open: RST_RIGHT_OPEN,
		left_hopper: RST_LEFT_HOPPER, right_hopper: RST_RIGHT_HOPPER,
		left_close: RST_LEFT_CLOSE, right_close: RST_RIGHT_CLOSE};
	angle_t cur_l = '0, cur_r = '0, tgt_l = '0, tgt_r = '0;
	logic [ELAPSED_W-1:0] elapsed_ms = '0;
	logic [SETTLE_W-1:0] settle_limit = '0;
	bit started = 1'b0;
	bit moving = 1'b0;

	// stimulus-side guess of where the gripper is heading
	angle_t guess_l = angle_t'(ANGLE_MAX);
	angle_t guess_r = angle_t'(ANGLE_MAX);

	function automatic int unsigned angle_gap(angle_t a, angle_t b);
		return (a >= b) ? int'(a - b) : int'(b - a);
	endfunction

	function automatic bit within_tol(angle_t a, angle_t b);
		return angle_gap(a, b) <= ANGLE_TOL;
	endfunction

	function automatic angle_t clamp_to_limits(angle_t a);
		if (a < tracker_cfg.clamp_low)
			return tracker_cfg.clamp_low;
		if (a > tracker_cfg.clamp_high)
			return tracker_cfg.clamp_high;
		return a;
	endfunction

	function automatic void complete_if_settled();
		if (started && moving && elapsed_ms >= ELAPSED_W'(settle_limit)) begin
			cur_l = tgt_l;
			cur_r = tgt_r;
			moving = 1'b0;
			settles_done++;
		end
	endfunction

	// round(span * 100 / speed) + margin, half rounds up
	function automatic logic [SETTLE_W-1:0] settle_estimate(angle_t lt, angle_t rt,
			logic [SPEED_W-1:0] spd);
		int unsigned dl, dr, span, rate, q;
		dl = angle_gap(lt, cur_l);
		dr = angle_gap(rt, cur_r);
		span = (dl >= dr) ? dl : dr;
		rate = (spd <= 1) ? 1 : spd;
		q = (span * ROUND_SCALE + rate) / (2 * rate);
		return SETTLE_W'(q + SETTLE_MARGIN);
	endfunction

	function automatic servo_status_t predict_status(servo_item_t it);
		servo_status_t res;
		angle_t lt, rt;
		logic drove;
		res = '0;
		drove = 1'b0;
		if (it.op == OP_TICK) begin
			ticks_taken++;
			if (elapsed_ms != '1)
				elapsed_ms = elapsed_ms + 1'b1;
		end else begin
			moves_taken++;
			lt = clamp_to_limits(it.lreq);
			rt = clamp_to_limits(it.rreq);
			if (!started) begin
				cur_l = tracker_cfg.left_close;
				tgt_l = tracker_cfg.left_close;
				cur_r = tracker_cfg.right_close;
				tgt_r = tracker_cfg.right_close;
				elapsed_ms = '0;
				settle_limit = '0;
				started = 1'b1;
				moving = 1'b0;
				drove = 1'b1;
			end
			complete_if_settled();
			if (!(within_tol(lt, tgt_l) && within_tol(rt, tgt_r))) begin
				settle_limit = settle_estimate(lt, rt, it.speed);
				tgt_l = lt;
				tgt_r = rt;
				elapsed_ms = '0;
				moving = 1'b1;
				drove = 1'b1;
				moves_driven++;
			end
		end
		res.drive_valid = drove;
		res.data.left_drive = tgt_l;
		res.data.right_drive = tgt_r;
		// status always reflects a move that just ran out
		complete_if_settled();
		res.data.settle_time = settle_limit;
		res.data.busy_res = moving;
		res.data.is_open = !moving && within_tol(cur_l, tracker_cfg.left_open) &&
			within_tol(cur_r, tracker_cfg.right_open);
		res.data.is_hopper_open = !moving && within_tol(cur_l, tracker_cfg.left_hopper) &&
			within_tol(cur_r, tracker_cfg.right_hopper);
		res.data.is_closed = !moving && within_tol(cur_l, tracker_cfg.left_close) &&
			within_tol(cur_r, tracker_cfg.right_close);
		return res;
	endfunction

	task automatic note_mismatch(string field, logic [31:0] got, logic [31:0] want);
		if (mismatch_count < 25)
			$display("[%0t] result %0d: %s got %0h, expected %0h",
				$realtime, results_seen, field, got, want);
		mismatch_count++;
	endtask

	// input driver: acceptance at the rising edge, new values at the falling edge
	always @(posedge clk) begin
		cmd_taken = s_axis_tvalid && s_axis_tready;
		if (cmd_taken)
			status_due.push_back(predict_status(item_backlog.pop_front()));
	end

	always @(negedge clk) begin
		in_data_t word;
		if (!s_axis_tvalid || cmd_taken) begin
			if (arst_n && item_backlog.size() != 0 &&
					$urandom_range(0, 99) >= sender_idle_pct) begin
				word.left_request = item_backlog[0].lreq;
				word.right_request = item_backlog[0].rreq;
				word.speed = item_backlog[0].speed;
				s_axis_tdata <= word;
				s_axis_tuser <= item_backlog[0].op;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus a long hold-off when ordered
	always @(negedge clk) begin
		if (hold_orders != hold_orders_taken) begin
			hold_orders_taken = hold_orders;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		servo_status_t want;
		out_data_t got;
		if (m_axis_tvalid && m_axis_tready) begin
			got = out_data_t'(m_axis_tdata);
			results_seen++;
			if (status_due.size() == 0) begin
				note_mismatch("unexpected transaction", m_axis_tdata[31:0], '0);
			end else begin
				want = status_due.pop_front();
				if (m_axis_tuser[0] !== want.drive_valid)
					note_mismatch("drive_valid", m_axis_tuser[0], want.drive_valid);
				if (got.left_drive !== want.data.left_drive)
					note_mismatch("left_drive", got.left_drive, want.data.left_drive);
				if (got.right_drive !== want.data.right_drive)
					note_mismatch("right_drive", got.right_drive, want.data.right_drive);
				if (got.settle_time !== want.data.settle_time)
					note_mismatch("settle_time", got.settle_time, want.data.settle_time);
				if (got.busy_res !== want.data.busy_res)
					note_mismatch("busy_res", got.busy_res, want.data.busy_res);
				if (got.is_open !== want.data.is_open)
					note_mismatch("is_open", got.is_open, want.data.is_open);
				if (got.is_hopper_open !== want.data.is_hopper_open)
					note_mismatch("is_hopper_open", got.is_hopper_open,
						want.data.is_hopper_open);
				if (got.is_closed !== want.data.is_closed)
					note_mismatch("is_closed", got.is_closed, want.data.is_closed);
				if (got.pad !== 2'b00)
					note_mismatch("pad", got.pad, 2'b00);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results pending",
				quiet_cycles, status_due.size());
			$display("gripper_servo_settle_tracker_core regression: fail");
			$finish;
		end
	end

	task automatic queue_item(op_t op, angle_t l, angle_t r, int spd);
		servo_item_t it;
		it.op = op;
		it.lreq = l;
		it.rreq = r;
		it.speed = SPEED_W'(spd);
		item_backlog.push_back(it);
		items_queued++;
	endtask

	task automatic queue_tick();
		queue_item(OP_TICK, angle_t'($urandom_range(0, ANGLE_MAX)),
			angle_t'($urandom_range(0, ANGLE_MAX)), $urandom_range(0, SPEED_MAX));
	endtask

	function automatic angle_t nudge(angle_t a, int lo, int hi);
		int v;
		v = $urandom_range(lo, hi);
		v = $urandom_range(0, 1) ? int'(a) + v : int'(a) - v;
		if (v < 0)
			v = 0;
		if (v > ANGLE_MAX)
			v = ANGLE_MAX;
		return angle_t'(v);
	endfunction

	// one command followed by ticks sized to about its settle time,
	// sometimes cut short, sometimes just loose noise
	task automatic queue_burst();
		int pick, ticks, est, span, rate;
		angle_t l, r;
		int spd;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 6))
				queue_item(op_t'($urandom_range(0, 1)),
					angle_t'($urandom_range(0, ANGLE_MAX)),
					angle_t'($urandom_range(0, ANGLE_MAX)), $urandom_range(0, SPEED_MAX));
			return;
		end
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			l = nudge(guess_l, 11, 120);
			r = nudge(guess_r, 0, 120);
		end else if (pick < 50) begin
			l = nudge(guess_l, 0, ANGLE_TOL);
			r = nudge(guess_r, 0, ANGLE_TOL);
		end else if (pick < 80) begin
			case ($urandom_range(0, 2))
				0: begin
					l = nudge(tracker_cfg.left_open, 0, 12);
					r = nudge(tracker_cfg.right_open, 0, 12);
				end
				1: begin
					l = nudge(tracker_cfg.left_hopper, 0, 12);
					r = nudge(tracker_cfg.right_hopper, 0, 12);
				end
				default: begin
					l = nudge(tracker_cfg.left_close, 0, 12);
					r = nudge(tracker_cfg.right_close, 0, 12);
				end
			endcase
		end else begin
			l = angle_t'($urandom_range(0, ANGLE_MAX));
			r = angle_t'($urandom_range(0, ANGLE_MAX));
		end
		pick = $urandom_range(0, 99);
		if (pick < 70)
			spd = $urandom_range(700, SPEED_MAX);
		else if (pick < 85)
			spd = $urandom_range(0, 3);
		else
			spd = $urandom_range(0, SPEED_MAX);
		span = angle_gap(l, guess_l);
		if (angle_gap(r, guess_r) > span)
			span = angle_gap(r, guess_r);
		rate = (spd < 1) ? 1 : spd;
		est = span * 100 / rate + SETTLE_MARGIN;
		if ($urandom_range(0, 3) == 0 || est > 320)
			ticks = $urandom_range(0, 25);
		else
			ticks = est - 2 + $urandom_range(0, 6);
		queue_item(OP_MOVE, l, r, spd);
		guess_l = l;
		guess_r = r;
		repeat (ticks)
			queue_tick();
	endtask

	task automatic settle_all();
		while (item_backlog.size() != 0 || status_due.size() != 0)
			@(posedge clk);
		repeat (30)
			@(posedge clk);
	endtask

	task automatic run_traffic(int n);
		int goal;
		goal = items_queued + n;
		while (items_queued < goal) begin
			queue_burst();
			while (item_backlog.size() > 64)
				@(posedge clk);
			// now and then let everything drain before sending more
			if ($urandom_range(0, 19) == 0)
				settle_all();
		end
	endtask

	task automatic write_reg(reg_idx_t idx, angle_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		case (idx)
			REG_CLAMP_LOW:    tracker_cfg.clamp_low = val;
			REG_CLAMP_HIGH:   tracker_cfg.clamp_high = val;
			REG_LEFT_OPEN:    tracker_cfg.left_open = val;
			REG_RIGHT_OPEN:   tracker_cfg.right_open = val;
			REG_LEFT_HOPPER:  tracker_cfg.left_hopper = val;
			REG_RIGHT_HOPPER: tracker_cfg.right_hopper = val;
			REG_LEFT_CLOSE:   tracker_cfg.left_close = val;
			REG_RIGHT_CLOSE:  tracker_cfg.right_close = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// valid stays high across the eight writes
	task automatic apply_settings(cfg_regs_t v);
		@(negedge clk);
		write_reg(REG_CLAMP_LOW, v.clamp_low);
		write_reg(REG_CLAMP_HIGH, v.clamp_high);
		write_reg(REG_LEFT_OPEN, v.left_open);
		write_reg(REG_RIGHT_OPEN, v.right_open);
		write_reg(REG_LEFT_HOPPER, v.left_hopper);
		write_reg(REG_RIGHT_HOPPER, v.right_hopper);
		write_reg(REG_LEFT_CLOSE, v.left_close);
		write_reg(REG_RIGHT_CLOSE, v.right_close);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	initial begin
		cfg_regs_t pose_set;
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3)
			@(posedge clk);

		// directed: reset settings, no idling
		queue_item(OP_TICK, 11'd0, 11'd0, 0);          // before any command
		queue_item(OP_TICK, 11'd1800, 11'd1800, SPEED_MAX);
		queue_item(OP_MOVE, 11'd1800, 11'd1800, 500);  // first use, then ignored
		queue_item(OP_MOVE, 11'd0, 11'd0, 0);          // zero speed
		queue_item(OP_MOVE, 11'd1800, 11'd0, 1);       // redirect mid-move
		queue_item(OP_MOVE, 11'd1795, 11'd5, SPEED_MAX); // inside tolerance
		queue_item(OP_MOVE, 11'd1789, 11'd11, SPEED_MAX); // just outside
		queue_item(OP_MOVE, 11'd1800, 11'd1800, SPEED_MAX);
		queue_item(OP_MOVE, 11'd0, 11'd1800, 999);
		queue_item(OP_MOVE, 11'd1800, 11'd1800, 2);
		repeat (12)
			queue_tick();
		queue_item(OP_MOVE, 11'd1800, 11'd1800, SPEED_MAX);
		// hold the output off while the sender keeps going
		hold_orders++;
		run_traffic(250);
		settle_all();

		pose_set = '{clamp_low: 11'd100, clamp_high: 11'd1700,
			left_open: 11'd300, right_open: 11'd350,
			left_hopper: 11'd900, right_hopper: 11'd950,
			left_close: 11'd1500, right_close: 11'd1450};
		apply_settings(pose_set);
		sender_idle_pct = 75;
		run_traffic(300);
		settle_all();

		// crossed clamp limits and extreme poses
		pose_set = '{clamp_low: 11'd1800, clamp_high: 11'd0,
			left_open: 11'd1800, right_open: 11'd0,
			left_hopper: 11'd0, right_hopper: 11'd1800,
			left_close: 11'd0, right_close: 11'd0};
		sender_idle_pct = 0;
		stall_pct = 75;
		apply_settings(pose_set);
		run_traffic(300);
		settle_all();

		pose_set = '{clamp_low: 11'd0, clamp_high: 11'd1800,
			left_open: 11'd0, right_open: 11'd0,
			left_hopper: 11'd1800, right_hopper: 11'd1800,
			left_close: 11'd1800, right_close: 11'd1800};
		sender_idle_pct = 31;
		stall_pct = 31;
		apply_settings(pose_set);
		run_traffic(300);
		settle_all();

		pose_set.clamp_low = angle_t'($urandom_range(0, 900));
		pose_set.clamp_high = angle_t'($urandom_range(900, ANGLE_MAX));
		pose_set.left_open = angle_t'($urandom_range(0, ANGLE_MAX));
		pose_set.right_open = angle_t'($urandom_range(0, ANGLE_MAX));
		pose_set.left_hopper = angle_t'($urandom_range(0, ANGLE_MAX));
		pose_set.right_hopper = angle_t'($urandom_range(0, ANGLE_MAX));
		pose_set.left_close = angle_t'($urandom_range(0, ANGLE_MAX));
		pose_set.right_close = angle_t'($urandom_range(0, ANGLE_MAX));
		sender_idle_pct = 0;
		stall_pct = 0;
		apply_settings(pose_set);
		run_traffic(300);
		settle_all();
		repeat (40)
			@(posedge clk);

		$display("covered %0d items (%0d ticks, %0d commands) over %0d register settings",
			ticks_taken + moves_taken, ticks_taken, moves_taken, settings_used);
		$display("%0d status words checked, %0d moves driven, %0d settles completed",
			results_seen, moves_driven, settles_done);
		if (mismatch_count == 0)
			$display("gripper_servo_settle_tracker_core regression: pass");
		else
			$display("gripper_servo_settle_tracker_core regression: fail");
		$finish;
	end

endmodule
